/* hw/rtl/kl_pkg.sv */
// keyword lexer package: scan modes, token kinds, queue entry types and constants
// keyword match function shared by the front end
// no dependencies
`default_nettype none

package kl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUMBER,
        MODE_COLON
    } scan_mode_t;

    typedef enum logic [3:0] {
        TK_INVALID  = 4'd0,
        TK_PLUS     = 4'd1,
        TK_MINUS    = 4'd2,
        TK_MULTIPLY = 4'd3,
        TK_DIVIDE   = 4'd4,
        TK_NUMBER   = 4'd5,
        TK_LET      = 4'd6,
        TK_IDENT    = 4'd7,
        TK_ASSIGN   = 4'd8,
        TK_TYPE     = 4'd9,
        TK_INT      = 4'd10,
        TK_EOF      = 4'd11
    } token_kind_t;

    // one queue entry: first token carries the payload, second never does
    typedef struct packed {
        logic        two;
        token_kind_t kind0;
        token_kind_t kind1;
    } entry_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IDENT_BYTES = 8;
    localparam int IDENT_W     = 8 * IDENT_BYTES;
    localparam int LEN_W       = 4;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;

    // keywords packed first character in lowest byte
    localparam logic [IDENT_W-1:0] KW_PLUS     = 64'h0000_0000_7375_6c70;
    localparam logic [IDENT_W-1:0] KW_MINUS    = 64'h0000_0073_756e_696d;
    localparam logic [IDENT_W-1:0] KW_MULTIPLY = 64'h796c_7069_746c_756d;
    localparam logic [IDENT_W-1:0] KW_DIVIDE   = 64'h0000_6564_6976_6964;
    localparam logic [IDENT_W-1:0] KW_LET      = 64'h0000_0000_0074_656c;
    localparam logic [IDENT_W-1:0] KW_INTEGER  = 64'h0072_6567_6574_6e69;

    function automatic token_kind_t word_kind(
        input logic [IDENT_W-1:0] wbuf,
        input logic [LEN_W-1:0]   wcnt,
        input logic               wovf
    );
        token_kind_t kind;
        kind = TK_IDENT;
        if (!wovf)
        begin
            if (wcnt == LEN_W'(4) && wbuf == KW_PLUS)
                kind = TK_PLUS;
            else if (wcnt == LEN_W'(5) && wbuf == KW_MINUS)
                kind = TK_MINUS;
            else if (wcnt == LEN_W'(8) && wbuf == KW_MULTIPLY)
                kind = TK_MULTIPLY;
            else if (wcnt == LEN_W'(6) && wbuf == KW_DIVIDE)
                kind = TK_DIVIDE;
            else if (wcnt == LEN_W'(3) && wbuf == KW_LET)
                kind = TK_LET;
            else if (wcnt == LEN_W'(7) && wbuf == KW_INTEGER)
                kind = TK_INT;
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/kl_front.sv */
// keyword lexer front end: takes character words, tracks the scan state and
// builds one queue entry of up to two tokens per word; uses kl_pkg
`default_nettype none

module kl_front #(
    parameter int NUMBER_BITS = 31,
    parameter int PAYLOAD_W   = NUMBER_BITS + 70
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,
    input  wire logic                   s_tuser,
    input  wire kl_pkg::queue_stat_t    q_stat,
    output logic                        push,
    output kl_pkg::entry_ctrl_t         push_ctrl,
    output logic [PAYLOAD_W-1:0]        push_data,
    output kl_pkg::scan_mode_t          mode
);

    localparam int PROD_W    = NUMBER_BITS + 4;
    localparam int OFS_SAT   = NUMBER_BITS;
    localparam int OFS_CHARS = NUMBER_BITS + 1;
    localparam int OFS_LEN   = OFS_CHARS + kl_pkg::IDENT_W;
    localparam int OFS_TRUNC = OFS_LEN + kl_pkg::LEN_W;

    kl_pkg::scan_mode_t               mode_reg, mode_next;
    logic [kl_pkg::IDENT_W-1:0]       wbuf_reg, wbuf_next;
    logic [kl_pkg::LEN_W-1:0]         wcnt_reg, wcnt_next;
    logic                             wovf_reg, wovf_next;
    logic [NUMBER_BITS-1:0]           acc_reg, acc_next;
    logic                             novf_reg, novf_next;

    logic                             accept;
    logic [7:0]                       c;
    logic                             is_letter;
    logic                             is_digit;
    logic [PROD_W-1:0]                prod;
    kl_pkg::token_kind_t              wkind;
    logic                             flush_vld;
    kl_pkg::token_kind_t              flush_kind;
    logic [PAYLOAD_W-1:0]             flush_data;
    logic                             use_flush;
    logic                             second_vld;
    kl_pkg::token_kind_t              second_kind;
    logic                             first_is_flush;

    assign s_tready = !q_stat.full;
    assign mode     = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= kl_pkg::MODE_IDLE;
            wbuf_reg <= '0;
            wcnt_reg <= '0;
            wovf_reg <= 1'b0;
            acc_reg  <= '0;
            novf_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            wbuf_reg <= wbuf_next;
            wcnt_reg <= wcnt_next;
            wovf_reg <= wovf_next;
            acc_reg  <= acc_next;
            novf_reg <= novf_next;
        end
    end

    always_comb
    begin
        accept    = s_tvalid && s_tready;
        c         = s_tdata;
        is_letter = c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
        is_digit  = c inside {[8'h30:8'h39]};
        prod      = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(c[3:0]);
        wkind     = kl_pkg::word_kind(wbuf_reg, wcnt_reg, wovf_reg);

        mode_next = mode_reg;
        wbuf_next = wbuf_reg;
        wcnt_next = wcnt_reg;
        wovf_next = wovf_reg;
        acc_next  = acc_reg;
        novf_next = novf_reg;

        // pending token of the current mode
        flush_vld  = mode_reg != kl_pkg::MODE_IDLE;
        flush_kind = kl_pkg::TK_TYPE;
        flush_data = '0;
        case (mode_reg)
            kl_pkg::MODE_WORD:
            begin
                flush_kind = wkind;
                if (wkind == kl_pkg::TK_IDENT)
                begin
                    flush_data[OFS_CHARS +: kl_pkg::IDENT_W] = wbuf_reg;
                    flush_data[OFS_LEN +: kl_pkg::LEN_W]     = wcnt_reg;
                    flush_data[OFS_TRUNC]                    = wovf_reg;
                end
            end
            kl_pkg::MODE_NUMBER:
            begin
                flush_kind                     = kl_pkg::TK_NUMBER;
                flush_data[NUMBER_BITS-1:0]    = acc_reg;
                flush_data[OFS_SAT]            = novf_reg;
            end
            kl_pkg::MODE_COLON:
            begin
                flush_kind = kl_pkg::TK_TYPE;
            end
            default:
            begin
                flush_kind = kl_pkg::TK_TYPE;
            end
        endcase

        use_flush   = 1'b0;
        second_vld  = 1'b0;
        second_kind = kl_pkg::TK_EOF;

        if (accept)
        begin
            if (s_tuser)
            begin
                use_flush   = 1'b1;
                second_vld  = 1'b1;
                second_kind = kl_pkg::TK_EOF;
                mode_next   = kl_pkg::MODE_IDLE;
            end
            else if (mode_reg == kl_pkg::MODE_WORD && (is_letter || is_digit))
            begin
                if (wcnt_reg < kl_pkg::LEN_W'(kl_pkg::IDENT_BYTES))
                begin
                    for (int i = 0; i < kl_pkg::IDENT_BYTES; i++)
                    begin
                        if (wcnt_reg[2:0] == 3'(i))
                            wbuf_next[8*i +: 8] = c;
                    end
                    wcnt_next = wcnt_reg + 1'b1;
                end
                else
                begin
                    wovf_next = 1'b1;
                end
            end
            else if (mode_reg == kl_pkg::MODE_NUMBER && is_digit)
            begin
                if (prod[PROD_W-1:NUMBER_BITS] != '0)
                begin
                    acc_next  = '1;
                    novf_next = 1'b1;
                end
                else
                begin
                    acc_next = prod[NUMBER_BITS-1:0];
                end
            end
            else if (mode_reg == kl_pkg::MODE_COLON && c == kl_pkg::CH_EQUALS)
            begin
                mode_next   = kl_pkg::MODE_IDLE;
                second_vld  = 1'b1;
                second_kind = kl_pkg::TK_ASSIGN;
            end
            else
            begin
                use_flush = 1'b1;
                mode_next = kl_pkg::MODE_IDLE;
                if (c == kl_pkg::CH_SPACE || c == kl_pkg::CH_NEWLINE)
                begin
                    mode_next = kl_pkg::MODE_IDLE;
                end
                else if (is_letter)
                begin
                    mode_next = kl_pkg::MODE_WORD;
                    wbuf_next = kl_pkg::IDENT_W'(c);
                    wcnt_next = kl_pkg::LEN_W'(1);
                    wovf_next = 1'b0;
                end
                else if (is_digit)
                begin
                    mode_next = kl_pkg::MODE_NUMBER;
                    acc_next  = NUMBER_BITS'(c[3:0]);
                    novf_next = 1'b0;
                end
                else if (c == kl_pkg::CH_COLON)
                begin
                    mode_next = kl_pkg::MODE_COLON;
                end
                else
                begin
                    second_vld  = 1'b1;
                    second_kind = kl_pkg::TK_INVALID;
                end
            end
        end

        first_is_flush  = use_flush && flush_vld;
        push            = first_is_flush || second_vld;
        push_ctrl.two   = first_is_flush && second_vld;
        push_ctrl.kind0 = first_is_flush ? flush_kind : second_kind;
        push_ctrl.kind1 = second_kind;
        push_data       = first_is_flush ? flush_data : '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/kl_queue.sv */
// keyword lexer token queue: short fifo of entries between front and back end
// uses kl_pkg
`default_nettype none

module kl_queue #(
    parameter int DATA_W = 101
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire kl_pkg::entry_ctrl_t    push_ctrl,
    input  wire logic [DATA_W-1:0]      push_data,
    input  wire logic                   pop,
    output kl_pkg::entry_ctrl_t         head_ctrl,
    output logic [DATA_W-1:0]           head_data,
    output kl_pkg::queue_stat_t         stat
);

    kl_pkg::entry_ctrl_t          ctrl_mem [kl_pkg::QUEUE_DEPTH];
    logic [DATA_W-1:0]            data_mem [kl_pkg::QUEUE_DEPTH];

    logic [kl_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [kl_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [kl_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == kl_pkg::QPTR_W'(kl_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == kl_pkg::QPTR_W'(kl_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase

        head_ctrl  = ctrl_mem[rd_ptr_reg];
        head_data  = data_mem[rd_ptr_reg];
        stat.full  = cnt_reg == kl_pkg::QCNT_W'(kl_pkg::QUEUE_DEPTH);
        stat.empty = cnt_reg == '0;
    end

endmodule

`default_nettype wire

/* hw/rtl/kl_back.sv */
// keyword lexer back end: drains queue entries one token per word into the
// output register; uses kl_pkg
`default_nettype none

module kl_back #(
    parameter int PAYLOAD_W = 101,
    parameter int TDATA_W   = 112
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire kl_pkg::entry_ctrl_t    head_ctrl,
    input  wire logic [PAYLOAD_W-1:0]   head_data,
    input  wire kl_pkg::queue_stat_t    q_stat,
    output logic                        pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_W-1:0]          m_tdata,
    output logic                        m_tlast
);

    logic                  valid_reg, valid_next;
    logic [TDATA_W-1:0]    tdata_reg, tdata_next;
    logic                  tlast_reg, tlast_next;
    logic                  sub_reg, sub_next;
    logic                  load;

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    always_comb
    begin
        load       = !q_stat.empty && (!valid_reg || m_tready);
        valid_next = valid_reg && !m_tready;
        tdata_next = tdata_reg;
        tlast_next = tlast_reg;
        sub_next   = sub_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (!sub_reg)
            begin
                tdata_next = TDATA_W'({head_data, head_ctrl.kind0});
                tlast_next = !head_ctrl.two;
                if (head_ctrl.two)
                    sub_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                // second token of an entry: eof or invalid, no payload
                tdata_next = TDATA_W'(head_ctrl.kind1);
                tlast_next = 1'b1;
                sub_next   = 1'b0;
                pop        = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/keyword_lexer_core.sv */
// keyword lexer top level: front end, token queue and back end
// depends on kl_pkg, kl_front, kl_queue, kl_back
//
// Takes one character word per cycle (tuser high marks end of input) and
// emits tokens: keywords, identifiers of up to eight characters, saturating
// decimal numbers, assign, type, invalid and eof. A character is accepted
// every cycle while the four-entry token queue has room; each character
// yields zero, one or two tokens, and the output register sends one token
// per cycle while m_tready is high, so the queue absorbs the extra tokens
// of characters that give two. A completed token is written to the queue and
// then the output register, and tlast marks the last token of one input word.
`default_nettype none

module keyword_lexer_core #(
    parameter int NUMBER_BITS = 31
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // char_code
    input  wire logic                   s_tuser,   // end_of_input
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // token_kind, number_value, number_saturated, ident_chars, ident_length,
    // ident_truncated, zero fill
    output logic [((NUMBER_BITS + 74 + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                        m_tlast    // last
);

    localparam int PAYLOAD_W = NUMBER_BITS + 70;
    localparam int TDATA_W   = ((NUMBER_BITS + 74 + 7) / 8) * 8;

    logic                   push;
    kl_pkg::entry_ctrl_t    push_ctrl;
    logic [PAYLOAD_W-1:0]   push_data;
    logic                   pop;
    kl_pkg::entry_ctrl_t    head_ctrl;
    logic [PAYLOAD_W-1:0]   head_data;
    kl_pkg::queue_stat_t    q_stat;
    kl_pkg::scan_mode_t     front_mode;

    kl_front #(
        .NUMBER_BITS (NUMBER_BITS),
        .PAYLOAD_W   (PAYLOAD_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_data (push_data),
        .mode      (front_mode)
    );

    kl_queue #(
        .DATA_W (PAYLOAD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_data (push_data),
        .pop       (pop),
        .head_ctrl (head_ctrl),
        .head_data (head_data),
        .stat      (q_stat)
    );

    kl_back #(
        .PAYLOAD_W (PAYLOAD_W),
        .TDATA_W   (TDATA_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_ctrl (head_ctrl),
        .head_data (head_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_no_push_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(push && q_stat.full)
    ) else $error("token queue written while full");

    a_no_pop_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n)
        !(pop && q_stat.empty)
    ) else $error("token queue read while empty");

    a_idle_after_eof : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> (front_mode == kl_pkg::MODE_IDLE)
    ) else $error("scanner not idle after end of input");

endmodule

`default_nettype wire

/* tb/sv/keyword_lexer_core_test.sv */
// keyword_lexer_core_test: self-checking stream testbench for the keyword lexer
// a directed table then random character streams, checked by an in-house token predictor
// depends on kl_pkg and keyword_lexer_core
`timescale 1ns / 1ps

module keyword_lexer_core_test;

    import kl_pkg::*;

    localparam int NUM_W        = 31;
    localparam int TDATA_W      = ((NUM_W + 74 + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int MAX_REPORTS  = 10;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // fields from the lowest bit up: kind, value, clamped, chars, length, truncated
    typedef struct packed {
        logic                trunc;
        logic [LEN_W-1:0]    len;
        logic [IDENT_W-1:0]  chars;
        logic                sat;
        logic [NUM_W-1:0]    num;
        token_kind_t         kind;
    } token_t;

    localparam int TOKEN_W = $bits(token_t);

    typedef struct packed {
        logic   last;
        token_t tok;
    } token_word_t;

    // one character word; typed rows carry a single hand-written token
    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic        typed;
        token_kind_t kind;
    } char_word_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tlast;

    string       kw_text [6] = '{"plus", "minus", "multiply", "divide", "let", "integer"};
    token_kind_t kw_kind [6] = '{TK_PLUS, TK_MINUS, TK_MULTIPLY, TK_DIVIDE, TK_LET, TK_INT};

    char_word_t directed_rows [22] = '{
        '{8'h00, 1'b1, 1'b1, TK_EOF},
        '{8'h09, 1'b0, 1'b1, TK_INVALID},
        '{8'hff, 1'b0, 1'b1, TK_INVALID},
        '{8'h00, 1'b0, 1'b1, TK_INVALID},
        '{8'h80, 1'b0, 1'b1, TK_INVALID},
        '{CH_COLON, 1'b0, 1'b0, TK_INVALID},
        '{CH_EQUALS, 1'b0, 1'b1, TK_ASSIGN},
        '{CH_COLON, 1'b0, 1'b0, TK_INVALID},
        '{8'h7f, 1'b1, 1'b0, TK_INVALID},
        '{"z", 1'b0, 1'b0, TK_INVALID},
        '{"Z", 1'b0, 1'b0, TK_INVALID},
        '{8'hff, 1'b1, 1'b0, TK_INVALID},
        '{"9", 1'b0, 1'b0, TK_INVALID},
        '{CH_COLON, 1'b0, 1'b0, TK_INVALID},
        '{"A", 1'b0, 1'b0, TK_INVALID},
        '{"0", 1'b0, 1'b0, TK_INVALID},
        '{8'h0d, 1'b0, 1'b0, TK_INVALID},
        '{"l", 1'b0, 1'b0, TK_INVALID},
        '{"e", 1'b0, 1'b0, TK_INVALID},
        '{"t", 1'b0, 1'b0, TK_INVALID},
        '{CH_NEWLINE, 1'b0, 1'b0, TK_INVALID},
        '{8'h0d, 1'b0, 1'b1, TK_INVALID}
    };

    char_word_t  char_words [$];
    token_word_t expected_tokens [$];
    token_t      step_toks [$];

    // predictor state
    scan_mode_t          lex_mode;
    logic [IDENT_W-1:0]  word_bytes;
    logic [LEN_W-1:0]    word_len;
    logic                word_long;
    logic [NUM_W-1:0]    num_acc;
    logic                num_clamped;

    int          mismatches;
    int          idle_cycles;
    token_word_t seen_word;

    keyword_lexer_core #(
        .NUMBER_BITS(NUM_W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [IDENT_W-1:0] pack_text(string s);
        logic [IDENT_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic token_t plain_token(token_kind_t k);
        token_t t;
        t = '0;
        t.kind = k;
        return t;
    endfunction

    function automatic token_kind_t word_token_kind();
        if (word_long)
            return TK_IDENT;
        for (int i = 0; i < 6; i++)
            if (word_len == LEN_W'(kw_text[i].len()) && word_bytes == pack_text(kw_text[i]))
                return kw_kind[i];
        return TK_IDENT;
    endfunction

    task automatic flush_pending();
        token_t t;
        t = '0;
        if (lex_mode == MODE_WORD)
        begin
            t = plain_token(word_token_kind());
            if (t.kind == TK_IDENT)
            begin
                t.chars = word_bytes;
                t.len   = word_len;
                t.trunc = word_long;
            end
            step_toks.push_back(t);
        end
        else if (lex_mode == MODE_NUMBER)
        begin
            t = plain_token(TK_NUMBER);
            t.num = num_acc;
            t.sat = num_clamped;
            step_toks.push_back(t);
        end
        else if (lex_mode == MODE_COLON)
            step_toks.push_back(plain_token(TK_TYPE));
        lex_mode = MODE_IDLE;
    endtask

    task automatic start_token(logic [7:0] ch);
        if (ch == CH_SPACE || ch == CH_NEWLINE)
            return;
        if (is_alpha(ch))
        begin
            lex_mode   = MODE_WORD;
            word_bytes = IDENT_W'(ch);
            word_len   = LEN_W'(1);
            word_long  = 1'b0;
        end
        else if (is_num(ch))
        begin
            lex_mode    = MODE_NUMBER;
            num_acc     = NUM_W'(ch - 8'h30);
            num_clamped = 1'b0;
        end
        else if (ch == CH_COLON)
            lex_mode = MODE_COLON;
        else
            step_toks.push_back(plain_token(TK_INVALID));
    endtask

    // tokens caused by one character word, left in step_toks
    task automatic lex_step(logic [7:0] ch, logic eoi);
        logic [63:0] grown;
        step_toks.delete();
        if (eoi)
        begin
            flush_pending();
            step_toks.push_back(plain_token(TK_EOF));
        end
        else if (lex_mode == MODE_WORD && (is_alpha(ch) || is_num(ch)))
        begin
            if (word_len < LEN_W'(IDENT_BYTES))
            begin
                word_bytes[8*word_len +: 8] = ch;
                word_len = word_len + 1'b1;
            end
            else
                word_long = 1'b1;
        end
        else if (lex_mode == MODE_NUMBER && is_num(ch))
        begin
            grown = 64'(num_acc) * 64'd10 + 64'(ch - 8'h30);
            if (grown > 64'(NUM_MAX))
            begin
                num_acc     = NUM_MAX;
                num_clamped = 1'b1;
            end
            else
                num_acc = grown[NUM_W-1:0];
        end
        else if (lex_mode == MODE_COLON && ch == CH_EQUALS)
        begin
            lex_mode = MODE_IDLE;
            step_toks.push_back(plain_token(TK_ASSIGN));
        end
        else
        begin
            flush_pending();
            start_token(ch);
        end
    endtask

    task automatic expect_tokens(char_word_t w);
        token_word_t e;
        lex_step(w.ch, w.eoi);
        if (w.typed)
        begin
            step_toks.delete();
            step_toks.push_back(plain_token(w.kind));
        end
        foreach (step_toks[i])
        begin
            e.tok  = step_toks[i];
            e.last = (i == step_toks.size() - 1);
            expected_tokens.push_back(e);
        end
    endtask

    function automatic string describe(token_word_t w);
        return $sformatf("kind %0d num %0d sat %0b chars %h len %0d trunc %0b last %0b",
                         w.tok.kind, w.tok.num, w.tok.sat, w.tok.chars, w.tok.len,
                         w.tok.trunc, w.last);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 26)
            return 8'h61 + 8'(r);
        if (r < 52)
            return 8'h41 + 8'(r - 26);
        return 8'h30 + 8'(r - 52);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_char(logic [7:0] ch);
        char_words.push_back('{ch, 1'b0, 1'b0, TK_INVALID});
    endtask

    task automatic build_stimulus();
        int    pick;
        int    n;
        string s;
        logic [7:0] ch;
        foreach (directed_rows[i])
            char_words.push_back(directed_rows[i]);
        while (char_words.size() < $size(directed_rows) + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                // keywords, sometimes spoiled by case or a trailing character
                s = kw_text[$urandom_range(0, 5)];
                for (int i = 0; i < s.len(); i++)
                begin
                    ch = s[i];
                    if ($urandom_range(0, 19) == 0)
                        ch = ch ^ 8'h20;
                    add_char(ch);
                end
                if ($urandom_range(0, 9) == 0)
                    add_char(rand_alnum());
            end
            else if (pick < 40)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
                add_char(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25)));
                for (int i = 1; i < n; i++)
                    add_char(rand_alnum());
            end
            else if (pick < 58)
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    add_char(8'h30 + 8'($urandom_range(0, 9)));
            end
            else if (pick < 68)
            begin
                add_char(CH_COLON);
                if ($urandom_range(0, 9) < 6)
                    add_char(CH_EQUALS);
            end
            else if (pick < 78)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_char($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE);
            end
            else if (pick < 92)
                add_char(8'($urandom_range(0, 255)));
            else
                char_words.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b0, TK_INVALID});
            if ($urandom_range(0, 9) < 6)
                add_char($urandom_range(0, 3) == 0 ? CH_NEWLINE : CH_SPACE);
        end
        char_words.push_back('{8'($urandom_range(0, 255)), 1'b1, 1'b0, TK_INVALID});
    endtask

    // sender
    initial
    begin
        int         gap;
        int         calm;
        char_word_t w;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        lex_mode    = MODE_IDLE;
        word_bytes  = '0;
        word_len    = '0;
        word_long   = 1'b0;
        num_acc     = '0;
        num_clamped = 1'b0;
        calm        = 0;
        build_stimulus();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        foreach (char_words[i])
        begin
            w = char_words[i];
            if (calm > 0)
            begin
                calm--;
                gap = 0;
            end
            else
            begin
                gap = gap_len();
                if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(20, 80);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= w.ch;
            s_tuser  <= w.eoi;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            expect_tokens(w);
        end
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver
    initial
    begin
        int n;
        int calm;
        m_tready <= 1'b0;
        calm = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (calm > 0)
            begin
                calm--;
                n = 0;
            end
            else
            begin
                n = gap_len();
                if ($urandom_range(0, 19) == 0)
                    calm = $urandom_range(20, 80);
            end
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // token check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_word.last = m_tlast;
            seen_word.tok  = token_t'(m_tdata[TOKEN_W-1:0]);
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected token: %s", describe(seen_word));
            end
            else
            begin
                if (seen_word != expected_tokens[0] || m_tdata[TDATA_W-1:TOKEN_W] != '0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("token mismatch, expected %s", describe(expected_tokens[0]));
                        $display("               actual   %s fill %h", describe(seen_word),
                                 m_tdata[TDATA_W-1:TOKEN_W]);
                    end
                end
                void'(expected_tokens.pop_front());
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

endmodule
